### design/odt_pkg.sv
// Shared types and constants of the obstacle distance transform.
// Used by odt_engine and the top level; depends on nothing else.
`timescale 1ns / 1ps

package odt_pkg;

  localparam int MAX_WIDTH     = 64;
  localparam int MAX_HEIGHT    = 64;
  localparam int FRACTION_BITS = 8;

  localparam int X_W    = $clog2(MAX_WIDTH);
  localparam int Y_W    = $clog2(MAX_HEIGHT);
  localparam int ADDR_W = X_W + Y_W;
  localparam int DIM_W  = 7;
  localparam int DIST_W = 17;
  localparam int IDX_W  = 1;

  localparam logic [DIM_W-1:0]  DIM_MAX_W = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0]  DIM_MAX_H = DIM_W'(MAX_HEIGHT);
  localparam logic [DIST_W-1:0] DIST_INF  = '1;
  localparam logic [DIST_W-1:0] DIST_SAT  = DIST_INF - DIST_W'(1);

  localparam longint DIAG_SCALED =
    (64'd1414213562 * (64'd1 << FRACTION_BITS) + 64'd500000000) / 64'd1000000000;
  localparam logic [DIST_W-1:0] STEP_ORTHO = DIST_W'(1 << FRACTION_BITS);
  localparam logic [DIST_W-1:0] STEP_DIAG  = DIST_W'(DIAG_SCALED);

  localparam logic [1:0] OP_SET    = 2'd0;
  localparam logic [1:0] OP_RECOMP = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic KIND_READ   = 1'b0;
  localparam logic KIND_RECOMP = 1'b1;

  localparam logic [IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

  typedef struct packed {
    logic [1:0]     opcode;
    logic [X_W-1:0] cell_x;
    logic [Y_W-1:0] cell_y;
    logic           blocked;
  } in_item_t;

  typedef struct packed {
    logic              reply_kind;
    logic [DIST_W-1:0] clearance;
    logic              unreachable;
    logic              out_of_range;
  } out_item_t;

  typedef struct packed {
    logic              blk_rd_en;
    logic [ADDR_W-1:0] blk_addr;
    logic              clr_we;
    logic [ADDR_W-1:0] clr_addr;
    logic [DIST_W-1:0] clr_wdata;
  } eng_req_t;

endpackage

### design/odt_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing; instantiated for each store of the design.
`timescale 1ns / 1ps

module odt_ram #(
  parameter int DATA_W = 17,
  parameter int ADDR_W = 12
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/odt_engine.sv
// Recompute sequencer: seeds the work store, runs forward and backward
// raster sweeps, if any cell is blocked, until nothing changes, then
// copies into the clearance store. Depends on odt_pkg and odt_ram.
`timescale 1ns / 1ps

module odt_engine (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       go,
  input  logic [odt_pkg::DIM_W-1:0]  act_w,
  input  logic [odt_pkg::DIM_W-1:0]  act_h,
  input  logic                       blk_rd_data,
  output odt_pkg::eng_req_t          req,
  output logic                       done,
  output logic                       any_blocked
);

  typedef enum logic [2:0] {E_IDLE, E_INIT, E_FWD, E_BWD, E_COPY} eng_state_t;

  typedef struct packed {
    logic                       ok;
    logic                       diag;
    logic [odt_pkg::ADDR_W-1:0] addr;
  } slot_t;

  eng_state_t                 st_r, st_nxt;
  logic [odt_pkg::X_W-1:0]    x_r, x_nxt;
  logic [odt_pkg::Y_W-1:0]    y_r, y_nxt;
  logic [2:0]                 k_r, k_nxt;
  logic                       any_r, any_nxt;
  logic                       chg_r, chg_nxt;
  logic                       ok_r, ok_nxt;
  logic                       diag_r, diag_nxt;
  logic                       done_r, done_nxt;
  logic [odt_pkg::DIST_W-1:0] acc_r, acc_nxt;
  logic [odt_pkg::DIST_W-1:0] orig_r, orig_nxt;

  logic                       w_we, w_re;
  logic [odt_pkg::ADDR_W-1:0] w_waddr, w_raddr;
  logic [odt_pkg::DIST_W-1:0] w_wdata, w_rdata;

  logic [odt_pkg::DIM_W-1:0]  w_m1, h_m1;
  logic [odt_pkg::ADDR_W-1:0] self_addr;
  logic                       bwd, x_last, y_last, x_first, y_first, fwd_end, bwd_end;
  logic [odt_pkg::DIST_W:0]   sum;
  logic [odt_pkg::DIST_W-1:0] step, cand, best;
  logic                       chg_now, any_now;
  slot_t                      slot;

  function automatic slot_t slot_of(input logic [2:0] k, input logic back,
                                    input logic [odt_pkg::X_W-1:0] x,
                                    input logic [odt_pkg::Y_W-1:0] y,
                                    input logic [odt_pkg::DIM_W-1:0] w,
                                    input logic [odt_pkg::DIM_W-1:0] h);
    logic [odt_pkg::DIM_W-1:0] xe, xp, xm, ye, yp, ym, nx, ny;
    slot_t s;
    xe = odt_pkg::DIM_W'(x);
    ye = odt_pkg::DIM_W'(y);
    xp = xe + odt_pkg::DIM_W'(1);
    xm = xe - odt_pkg::DIM_W'(1);
    yp = ye + odt_pkg::DIM_W'(1);
    ym = ye - odt_pkg::DIM_W'(1);
    nx = xe;
    ny = ye;
    s.diag = 1'b0;
    case (k)
      3'd1: begin
        nx = back ? xp : xm;
      end
      3'd2: begin
        nx = back ? xp : xm;
        ny = back ? yp : ym;
        s.diag = 1'b1;
      end
      3'd3: begin
        ny = back ? yp : ym;
      end
      3'd4: begin
        nx = back ? xm : xp;
        ny = back ? yp : ym;
        s.diag = 1'b1;
      end
      default: begin
        nx = xe;
        ny = ye;
      end
    endcase
    s.ok   = (nx < w) && (ny < h);
    s.addr = {ny[odt_pkg::Y_W-1:0], nx[odt_pkg::X_W-1:0]};
    return s;
  endfunction

  odt_ram #(.DATA_W(odt_pkg::DIST_W), .ADDR_W(odt_pkg::ADDR_W)) u_work (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .re    (w_re),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  assign w_m1      = act_w - odt_pkg::DIM_W'(1);
  assign h_m1      = act_h - odt_pkg::DIM_W'(1);
  assign self_addr = {y_r, x_r};
  assign bwd       = (st_r == E_BWD);
  assign x_last    = (odt_pkg::DIM_W'(x_r) == w_m1);
  assign y_last    = (odt_pkg::DIM_W'(y_r) == h_m1);
  assign x_first   = (x_r == '0);
  assign y_first   = (y_r == '0);
  assign fwd_end   = x_last && y_last;
  assign bwd_end   = x_first && y_first;
  assign slot      = slot_of(k_r, bwd, x_r, y_r, act_w, act_h);

  assign step = diag_r ? odt_pkg::STEP_DIAG : odt_pkg::STEP_ORTHO;
  assign sum  = {1'b0, w_rdata} + {1'b0, step};
  assign cand = (w_rdata == odt_pkg::DIST_INF) ? odt_pkg::DIST_INF :
                (sum > {1'b0, odt_pkg::DIST_SAT}) ? odt_pkg::DIST_SAT :
                sum[odt_pkg::DIST_W-1:0];
  assign best    = (ok_r && (cand < acc_r)) ? cand : acc_r;
  assign chg_now = chg_r || (best < orig_r);
  assign any_now = any_r || blk_rd_data;

  always_comb begin
    st_nxt   = st_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    k_nxt    = k_r;
    any_nxt  = any_r;
    chg_nxt  = chg_r;
    ok_nxt   = ok_r;
    diag_nxt = diag_r;
    acc_nxt  = acc_r;
    orig_nxt = orig_r;
    done_nxt = 1'b0;
    w_we     = 1'b0;
    w_waddr  = self_addr;
    w_wdata  = best;
    w_re     = 1'b0;
    w_raddr  = self_addr;
    req      = '0;
    req.blk_addr  = self_addr;
    req.clr_addr  = self_addr;
    req.clr_wdata = w_rdata;
    case (st_r)
      E_IDLE: begin
        if (go) begin
          st_nxt  = E_INIT;
          x_nxt   = '0;
          y_nxt   = '0;
          k_nxt   = '0;
          any_nxt = 1'b0;
        end
      end
      E_INIT, E_COPY: begin
        if (k_r == 3'd0) begin
          req.blk_rd_en = (st_r == E_INIT);
          w_re          = (st_r == E_COPY);
          k_nxt         = 3'd1;
        end else begin
          k_nxt = 3'd0;
          if (st_r == E_INIT) begin
            w_we    = 1'b1;
            w_wdata = blk_rd_data ? '0 : odt_pkg::DIST_INF;
            any_nxt = any_now;
          end else begin
            req.clr_we = 1'b1;
          end
          if (fwd_end) begin
            x_nxt   = '0;
            y_nxt   = '0;
            chg_nxt = 1'b0;
            if (st_r == E_COPY) begin
              st_nxt   = E_IDLE;
              done_nxt = 1'b1;
            end else begin
              st_nxt = any_now ? E_FWD : E_COPY;
            end
          end else if (x_last) begin
            x_nxt = '0;
            y_nxt = y_r + odt_pkg::Y_W'(1);
          end else begin
            x_nxt = x_r + odt_pkg::X_W'(1);
          end
        end
      end
      E_FWD, E_BWD: begin
        if (k_r <= 3'd4) begin
          w_re     = 1'b1;
          w_raddr  = slot.addr;
          ok_nxt   = slot.ok;
          diag_nxt = slot.diag;
        end
        if (k_r == 3'd1) begin
          acc_nxt  = w_rdata;
          orig_nxt = w_rdata;
        end else if (k_r >= 3'd2 && k_r <= 3'd4) begin
          acc_nxt = best;
        end
        k_nxt = k_r + 3'd1;
        if (k_r == 3'd5) begin
          k_nxt   = 3'd0;
          w_we    = 1'b1;
          chg_nxt = chg_now;
          if (!bwd) begin
            if (fwd_end) begin
              st_nxt = E_BWD;
              x_nxt  = w_m1[odt_pkg::X_W-1:0];
              y_nxt  = h_m1[odt_pkg::Y_W-1:0];
            end else if (x_last) begin
              x_nxt = '0;
              y_nxt = y_r + odt_pkg::Y_W'(1);
            end else begin
              x_nxt = x_r + odt_pkg::X_W'(1);
            end
          end else begin
            if (bwd_end) begin
              st_nxt  = chg_now ? E_FWD : E_COPY;
              x_nxt   = '0;
              y_nxt   = '0;
              chg_nxt = 1'b0;
            end else if (x_first) begin
              x_nxt = w_m1[odt_pkg::X_W-1:0];
              y_nxt = y_r - odt_pkg::Y_W'(1);
            end else begin
              x_nxt = x_r - odt_pkg::X_W'(1);
            end
          end
        end
      end
      default: begin
        st_nxt = E_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= E_IDLE;
      k_r    <= '0;
      x_r    <= '0;
      y_r    <= '0;
      any_r  <= 1'b0;
      chg_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      k_r    <= k_nxt;
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      any_r  <= any_nxt;
      chg_r  <= chg_nxt;
      done_r <= done_nxt;
    end
    ok_r   <= ok_nxt;
    diag_r <= diag_nxt;
    acc_r  <= acc_nxt;
    orig_r <= orig_nxt;
  end

  assign done        = done_r;
  assign any_blocked = any_r;

endmodule

### design/obstacle_distance_transform.sv
// Top level of the obstacle distance transform: command decode, grid
// registers, blocked map and clearance store. Depends on odt_pkg, odt_ram
// and odt_engine.
//
// Channel  Ports                          Direction  Handshake
// input    start, busy, in_item           in         taken when start and not busy
// result   out_valid, out_item            out        one-cycle strobe, no back-pressure
// config   cfg_we, cfg_index, cfg_wdata   in         written when cfg_we is high
//
// A set or read command leaves busy low; a read reply appears in the cycle after
// the item is taken. A recompute runs forward/backward sweep pairs over the
// active cells when any is blocked; each cell costs six work-store accesses in a
// sweep. After reset a clearing pass over every address of the blocked map and
// clearance store holds busy high. Results are never stalled.
`timescale 1ns / 1ps

module obstacle_distance_transform (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  odt_pkg::in_item_t          in_item,
  output logic                       out_valid,
  output odt_pkg::out_item_t         out_item,
  input  logic                       cfg_we,
  input  logic [odt_pkg::IDX_W-1:0]  cfg_index,
  input  logic [odt_pkg::DIM_W-1:0]  cfg_wdata
);

  typedef enum logic [1:0] {T_CLEAR, T_IDLE, T_RECOMP} top_state_t;

  top_state_t                 st_r;
  logic [odt_pkg::ADDR_W-1:0] clr_idx_r;
  logic [odt_pkg::DIM_W-1:0]  grid_w_r, grid_h_r;
  logic                       out_valid_r, out_kind_r, oor_r, unreach_r;

  logic [odt_pkg::DIM_W-1:0]  act_w, act_h;
  logic                       accept, in_grid, clearing;
  logic [odt_pkg::ADDR_W-1:0] cmd_addr;

  logic                       blk_we, blk_wdata, blk_rdata;
  logic [odt_pkg::ADDR_W-1:0] blk_waddr;
  logic                       clr_we, clr_re;
  logic [odt_pkg::ADDR_W-1:0] clr_waddr;
  logic [odt_pkg::DIST_W-1:0] clr_wdata, clr_rdata;

  odt_pkg::eng_req_t          eng_req;
  logic                       eng_go, eng_done, eng_any;

  assign act_w = (grid_w_r == '0) ? odt_pkg::DIM_W'(1) :
                 (grid_w_r > odt_pkg::DIM_MAX_W) ? odt_pkg::DIM_MAX_W : grid_w_r;
  assign act_h = (grid_h_r == '0) ? odt_pkg::DIM_W'(1) :
                 (grid_h_r > odt_pkg::DIM_MAX_H) ? odt_pkg::DIM_MAX_H : grid_h_r;

  assign busy     = (st_r != T_IDLE);
  assign accept   = start && !busy;
  assign clearing = (st_r == T_CLEAR);
  assign in_grid  = (odt_pkg::DIM_W'(in_item.cell_x) < act_w) &&
                    (odt_pkg::DIM_W'(in_item.cell_y) < act_h);
  assign cmd_addr = {in_item.cell_y, in_item.cell_x};
  assign eng_go   = accept && (in_item.opcode == odt_pkg::OP_RECOMP);

  assign blk_we    = clearing || (accept && in_grid && (in_item.opcode == odt_pkg::OP_SET));
  assign blk_waddr = clearing ? clr_idx_r : cmd_addr;
  assign blk_wdata = clearing ? 1'b0 : in_item.blocked;

  assign clr_we    = clearing || eng_req.clr_we;
  assign clr_waddr = clearing ? clr_idx_r : eng_req.clr_addr;
  assign clr_wdata = clearing ? odt_pkg::DIST_INF : eng_req.clr_wdata;
  assign clr_re    = accept && in_grid && (in_item.opcode == odt_pkg::OP_READ);

  odt_ram #(.DATA_W(1), .ADDR_W(odt_pkg::ADDR_W)) u_blocked (
    .clk   (clk),
    .we    (blk_we),
    .waddr (blk_waddr),
    .wdata (blk_wdata),
    .re    (eng_req.blk_rd_en),
    .raddr (eng_req.blk_addr),
    .rdata (blk_rdata)
  );

  odt_ram #(.DATA_W(odt_pkg::DIST_W), .ADDR_W(odt_pkg::ADDR_W)) u_clearance (
    .clk   (clk),
    .we    (clr_we),
    .waddr (clr_waddr),
    .wdata (clr_wdata),
    .re    (clr_re),
    .raddr (cmd_addr),
    .rdata (clr_rdata)
  );

  odt_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .go          (eng_go),
    .act_w       (act_w),
    .act_h       (act_h),
    .blk_rd_data (blk_rdata),
    .req         (eng_req),
    .done        (eng_done),
    .any_blocked (eng_any)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= T_CLEAR;
      clr_idx_r   <= '0;
      grid_w_r    <= odt_pkg::DIM_MAX_W;
      grid_h_r    <= odt_pkg::DIM_MAX_H;
      out_valid_r <= 1'b0;
      out_kind_r  <= odt_pkg::KIND_READ;
      oor_r       <= 1'b0;
      unreach_r   <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          odt_pkg::REG_GRID_WIDTH:  grid_w_r <= cfg_wdata;
          odt_pkg::REG_GRID_HEIGHT: grid_h_r <= cfg_wdata;
          default: ;
        endcase
      end
      case (st_r)
        T_CLEAR: begin
          clr_idx_r <= clr_idx_r + odt_pkg::ADDR_W'(1);
          if (clr_idx_r == '1) begin
            st_r <= T_IDLE;
          end
        end
        T_IDLE: begin
          if (accept && in_item.opcode == odt_pkg::OP_RECOMP) begin
            st_r <= T_RECOMP;
          end else if (accept && in_item.opcode == odt_pkg::OP_READ) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= odt_pkg::KIND_READ;
            oor_r       <= !in_grid;
            unreach_r   <= 1'b0;
          end
        end
        T_RECOMP: begin
          if (eng_done) begin
            st_r        <= T_IDLE;
            out_valid_r <= 1'b1;
            out_kind_r  <= odt_pkg::KIND_RECOMP;
            oor_r       <= 1'b0;
            unreach_r   <= !eng_any;
          end
        end
        default: begin
          st_r <= T_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    out_item              = '0;
    out_item.reply_kind   = out_kind_r;
    out_item.out_of_range = oor_r;
    if (out_kind_r == odt_pkg::KIND_RECOMP) begin
      out_item.unreachable = unreach_r;
    end else if (!oor_r) begin
      out_item.clearance   = clr_rdata;
      out_item.unreachable = (clr_rdata == odt_pkg::DIST_INF);
    end
  end

  assign out_valid = out_valid_r;

  a_read_reply_timing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.reply_kind == odt_pkg::KIND_READ |->
      $past(start && !busy && in_item.opcode == odt_pkg::OP_READ))
    else $error("read reply without a read item in the previous cycle");

  a_oor_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_item.out_of_range |-> out_item.reply_kind == odt_pkg::KIND_READ)
    else $error("out-of-range flag on a recompute reply");

  a_done_in_recompute: assert property (@(posedge clk) disable iff (!rst_n)
    eng_done |-> st_r == T_RECOMP)
    else $error("recompute finished while no recompute was running");

  a_recomp_reply_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.reply_kind == odt_pkg::KIND_RECOMP |->
      !busy && out_item.clearance == '0)
    else $error("recompute reply while still busy or with a distance");

endmodule
